>>> hdl/sensor_frame_receiver_assert.svh
// assertion macros shared by the checker
`ifndef SENSOR_FRAME_RECEIVER_ASSERT_SVH
`define SENSOR_FRAME_RECEIVER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SFR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sensor_frame_receiver check failed");

// antecedent implies consequent in the next cycle
`define SFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sensor_frame_receiver check failed");

`endif

>>> hdl/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

  // link constants
  localparam logic [7:0] HEADER_BYTE   = 8'hAA;
  localparam logic [7:0] CRC_POLY      = 8'h8C;
  localparam logic [7:0] COIL_MASK     = 8'h03;
  localparam logic [7:0] COMP_MASK     = 8'h0C;
  localparam logic [7:0] HUMIDITY_MASK = 8'h7F;

  // top level sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_CRC,
    S_AVG,
    S_OUT
  } sfr_state_t;

  // averaging unit sequencer
  typedef enum logic [1:0] {
    A_IDLE,
    A_SUM,
    A_DIV
  } sfr_avg_state_t;

  // request to the crc unit
  typedef struct packed {
    logic       start;
    logic       clear;
    logic [7:0] data;
  } sfr_crc_req_t;

  // request to the averaging unit
  typedef struct packed {
    logic       start;
    logic [6:0] sample;
  } sfr_avg_req_t;

  // status from the averaging unit
  typedef struct packed {
    logic busy;
  } sfr_avg_stat_t;

endpackage

`default_nettype wire

>>> hdl/sfr_crc8.sv
`default_nettype none

module sfr_crc8 (
  input  wire                  clk,
  input  wire                  rst_n,
  input  sfr_pkg::sfr_crc_req_t req,
  output logic [7:0]           crc,
  output logic                 busy
);
  import sfr_pkg::*;

  logic [7:0] crc_r;
  logic [2:0] bit_cnt_r;
  logic       busy_r;
  logic [7:0] seed;

  // a restart seeds from zero
  assign seed = req.clear ? 8'h00 : crc_r;

  // one bit of the reflected crc per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r     <= 8'h00;
      bit_cnt_r <= 3'd0;
      busy_r    <= 1'b0;
    end else if (req.start) begin
      crc_r     <= seed ^ req.data;
      bit_cnt_r <= 3'd0;
      busy_r    <= 1'b1;
    end else if (busy_r) begin
      crc_r     <= crc_r[0] ? ((crc_r >> 1) ^ CRC_POLY) : (crc_r >> 1);
      bit_cnt_r <= bit_cnt_r + 3'd1;
      if (bit_cnt_r == 3'd7) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign crc  = crc_r;
  assign busy = busy_r;

endmodule

`default_nettype wire

>>> hdl/sfr_hum_avg.sv
`default_nettype none

module sfr_hum_avg #(
  parameter int AVERAGE_DEPTH = 5
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  sfr_pkg::sfr_avg_req_t  req,
  output sfr_pkg::sfr_avg_stat_t stat,
  output logic [6:0]            avg
);
  import sfr_pkg::*;

  localparam int IDX_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
  localparam int CNT_W = $clog2(AVERAGE_DEPTH + 1);
  localparam int SUM_W = $clog2(127 * AVERAGE_DEPTH + 1);
  localparam int DC_W  = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  sfr_avg_state_t state_r, state_nxt;

  logic [6:0]       hist_r [AVERAGE_DEPTH];
  logic [IDX_W-1:0] idx_r;
  logic             full_r;
  logic [CNT_W-1:0] n_r;
  logic [IDX_W-1:0] k_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0] dq_r;
  logic [CNT_W-1:0] rem_r;
  logic [DC_W-1:0]  dcnt_r;
  logic             idx_wrap;
  logic             sum_last;
  logic [CNT_W:0]   trial;
  logic             ge;

  assign idx_wrap = (idx_r == IDX_W'(AVERAGE_DEPTH - 1));
  assign sum_nxt  = sum_r + SUM_W'(hist_r[k_r]);
  assign sum_last = (CNT_W'(k_r) == (n_r - CNT_W'(1)));
  assign trial    = {rem_r, dq_r[SUM_W-1]};
  assign ge       = (trial >= {1'b0, n_r});

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      A_IDLE:  if (req.start) state_nxt = A_SUM;
      A_SUM:   if (sum_last) state_nxt = A_DIV;
      A_DIV:   if (dcnt_r == '0) state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    stat.busy = (state_r != A_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      idx_r   <= '0;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // history pointer and full flag
      if (state_r == A_IDLE && req.start) begin
        if (idx_wrap) begin
          idx_r  <= '0;
          full_r <= 1'b1;
        end else begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
    end
  end

  // history write, serial sum and restoring divide
  always_ff @(posedge clk) begin
    case (state_r)
      A_IDLE: begin
        if (req.start) begin
          hist_r[idx_r] <= req.sample;
          if (full_r || idx_wrap) begin
            n_r <= CNT_W'(AVERAGE_DEPTH);
          end else begin
            n_r <= CNT_W'(idx_r) + CNT_W'(1);
          end
          k_r   <= '0;
          sum_r <= '0;
        end
      end
      A_SUM: begin
        sum_r <= sum_nxt;
        k_r   <= k_r + IDX_W'(1);
        if (sum_last) begin
          dq_r   <= sum_nxt;
          rem_r  <= '0;
          dcnt_r <= DC_W'(SUM_W - 1);
        end
      end
      A_DIV: begin
        dq_r   <= {dq_r[SUM_W-2:0], ge};
        rem_r  <= ge ? CNT_W'(trial - {1'b0, n_r}) : trial[CNT_W-1:0];
        dcnt_r <= dcnt_r - DC_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign avg = dq_r[6:0];

endmodule

`default_nettype wire

>>> hdl/sensor_frame_receiver.sv
// a byte that is not the last of a frame holds in_stall while the bit-serial crc runs; a good
// last byte holds it through the serial sum over the held samples (AVERAGE_DEPTH at most), the
// restoring divide (10 quotient bits at default depth) and then the sequencer's S_OUT state
// the block takes no new byte until it is through with the last; one result per frame; a new
// result that finds the previous one still stalled waits in the sequencer and holds in_stall
// reset: rst_n synchronous active low, clears frame, crc, history pointer and output valid
`default_nettype none

module sensor_frame_receiver #(
  parameter int FRAME_BYTES   = 9,
  parameter int AVERAGE_DEPTH = 5
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_rx_byte,
  input  wire         in_frame_start,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_water_full_open,
  output logic        out_sleep_request,
  output logic        out_pan_motor_fault,
  output logic [8:0]  out_coil_reading,
  output logic [9:0]  out_compressor_reading,
  output logic [15:0] out_room_sensor_word,
  output logic [6:0]  out_humidity_avg,
  output logic        out_sensor_fault
);
  import sfr_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BYTES);

  sfr_state_t state_r, state_nxt;

  logic             active_r;
  logic [CNT_W-1:0] pos_r;
  logic             header_ok_r;
  logic [7:0]       store_r [7];
  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic [8:0]       out_coil_r;
  logic [9:0]       out_comp_r;
  logic [15:0]      out_room_r;
  logic [6:0]       out_hum_r;
  logic             out_fault_r;

  logic             in_acc;
  logic             frame_go;
  logic [CNT_W-1:0] pos_eff;
  logic             last_byte;
  logic             frame_good;
  logic             out_free;
  logic             out_load;
  logic [7:0]       crc;
  logic             crc_busy;
  sfr_crc_req_t     crc_req;
  sfr_avg_req_t     avg_req;
  sfr_avg_stat_t    avg_stat;
  logic [6:0]       avg_val;

  // transaction decode
  assign in_acc     = in_valid && !in_stall;
  assign frame_go   = in_acc && (in_frame_start || active_r);
  assign pos_eff    = in_frame_start ? '0 : pos_r;
  assign last_byte  = (pos_eff == CNT_W'(FRAME_BYTES - 1));
  assign frame_good = !in_frame_start && header_ok_r && (in_rx_byte == crc);
  assign out_free   = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (frame_go) begin
          if (!last_byte) begin
            state_nxt = S_CRC;
          end else if (frame_good) begin
            state_nxt = S_AVG;
          end
        end
      end
      S_CRC:   if (!crc_busy) state_nxt = S_IDLE;
      S_AVG:   if (!avg_stat.busy) state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall       = (state_r != S_IDLE);
    crc_req.start  = (state_r == S_IDLE) && frame_go && !last_byte;
    crc_req.clear  = in_frame_start;
    crc_req.data   = in_rx_byte;
    avg_req.start  = (state_r == S_IDLE) && frame_go && last_byte && frame_good;
    avg_req.sample = store_r[6][6:0] & HUMIDITY_MASK[6:0];
    out_load       = (state_r == S_OUT) && out_free;
  end

  // frame tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      pos_r       <= '0;
      header_ok_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (frame_go) begin
        if (!last_byte) begin
          active_r <= 1'b1;
          pos_r    <= pos_eff + CNT_W'(1);
          if (pos_eff == '0) begin
            header_ok_r <= (in_rx_byte == HEADER_BYTE);
          end
        end else begin
          active_r <= 1'b0;
          pos_r    <= '0;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload bytes one through seven
  always_ff @(posedge clk) begin
    if (frame_go && !last_byte && pos_eff != '0 && pos_eff <= CNT_W'(7)) begin
      store_r[3'(pos_eff - CNT_W'(1))] <= in_rx_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= store_r[0][2:0];
      out_coil_r   <= {store_r[1][1:0] & COIL_MASK[1:0], store_r[2][7:1]};
      out_comp_r   <= {store_r[1][3:2] & COMP_MASK[3:2], store_r[3]};
      out_room_r   <= {store_r[4], store_r[5]};
      out_hum_r    <= avg_val;
      out_fault_r  <= store_r[6][7];
    end
  end

  sfr_crc8 u_crc (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (crc_req),
    .crc  (crc),
    .busy (crc_busy)
  );

  sfr_hum_avg #(
    .AVERAGE_DEPTH(AVERAGE_DEPTH)
  ) u_avg (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (avg_req),
    .stat (avg_stat),
    .avg  (avg_val)
  );

  assign out_valid              = out_valid_r;
  assign out_water_full_open    = out_status_r[0];
  assign out_sleep_request      = out_status_r[1];
  assign out_pan_motor_fault    = out_status_r[2];
  assign out_coil_reading       = out_coil_r;
  assign out_compressor_reading = out_comp_r;
  assign out_room_sensor_word   = out_room_r;
  assign out_humidity_avg       = out_hum_r;
  assign out_sensor_fault       = out_fault_r;

endmodule

`default_nettype wire

>>> hdl/sfr_checker.sv
`default_nettype none
`include "sensor_frame_receiver_assert.svh"

module sfr_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_stall,
  input wire        in_frame_start,
  input wire        out_valid,
  input wire        out_stall,
  input wire [15:0] out_room_sensor_word,
  input wire [6:0]  out_humidity_avg
);

  // a stalled result holds
  `SFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable(out_room_sensor_word) && $stable(out_humidity_avg))

  // a frame start always begins crc work, so input stalls next cycle
  `SFR_ASSERT_NEXT(a_start_busy, clk, rst_n, in_valid && !in_stall && in_frame_start, in_stall)

  // a new result only appears while the input side is held off
  `SFR_ASSERT_SAME(a_result_busy, clk, rst_n, $rose(out_valid), $past(in_stall))

endmodule

bind sensor_frame_receiver sfr_checker u_sfr_checker (.*);

`default_nettype wire

>>> dv/sensor_frame_receiver_tb.sv
`default_nettype none

import sfr_pkg::*;

// one decoded sensor frame as seen on the result channel
typedef struct packed {
  logic        water_full_open;
  logic        sleep_request;
  logic        pan_motor_fault;
  logic [8:0]  coil_reading;
  logic [9:0]  compressor_reading;
  logic [15:0] room_sensor_word;
  logic [6:0]  humidity_avg;
  logic        sensor_fault;
} reading_t;

// tracks link bytes, predicts decoded readings and checks them in order
class frame_scoreboard;
  int unsigned frame_len;
  int unsigned avg_depth;
  bit [7:0]    crc;
  int unsigned byte_pos;
  bit          header_good;
  bit          in_frame;
  bit [7:0]    body[7];
  bit [6:0]    humidity_hist[];
  int unsigned hist_idx;
  bit          hist_full;
  reading_t    expected_readings[$];
  int unsigned mismatches;

  function new(int unsigned frame_bytes, int unsigned depth);
    frame_len     = frame_bytes;
    avg_depth     = depth;
    crc           = 8'h00;
    byte_pos      = 0;
    header_good   = 1'b0;
    in_frame      = 1'b0;
    humidity_hist = new[depth];
    hist_idx      = 0;
    hist_full     = 1'b0;
    mismatches    = 0;
  endfunction

  // reflected crc-8, one byte, lsb first
  function bit [7:0] crc_update(bit [7:0] acc, bit [7:0] data);
    bit [7:0] c;
    c = acc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  // moving average over the held humidity samples
  function bit [6:0] average_humidity(bit [6:0] sample);
    int unsigned sum;
    int unsigned n;
    sum = 0;
    humidity_hist[hist_idx] = sample;
    hist_idx++;
    if (hist_idx >= avg_depth) begin
      hist_idx  = 0;
      hist_full = 1'b1;
    end
    n = hist_full ? avg_depth : hist_idx;
    for (int k = 0; k < n; k++) sum += humidity_hist[k];
    return 7'(sum / n);
  endfunction

  // accepted input transaction: advance the frame and queue a reading if it checks out
  function void decode_link_byte(bit [7:0] b, bit start);
    reading_t    r;
    logic [31:0] t;
    if (start) begin
      in_frame    = 1'b1;
      byte_pos    = 0;
      crc         = 8'h00;
      header_good = 1'b0;
    end
    if (!in_frame) return;
    if (byte_pos < frame_len - 1) begin
      if (byte_pos == 0) header_good = (b == HEADER_BYTE);
      else if (byte_pos <= 7) body[byte_pos - 1] = b;
      crc = crc_update(crc, b);
      byte_pos++;
      return;
    end
    // last byte carries the crc
    in_frame = 1'b0;
    byte_pos = 0;
    if (!header_good || b != crc) return;
    r.water_full_open    = body[0][0];
    r.sleep_request      = body[0][1];
    r.pan_motor_fault    = body[0][2];
    t                    = ((body[1] & COIL_MASK) << 8) + body[2];
    r.coil_reading       = t[9:1];
    t                    = ((body[1] & COMP_MASK) << 6) + body[3];
    r.compressor_reading = t[9:0];
    r.room_sensor_word   = {body[4], body[5]};
    t                    = body[6] & HUMIDITY_MASK;
    r.humidity_avg       = average_humidity(t[6:0]);
    r.sensor_fault       = body[6][7];
    expected_readings.push_back(r);
  endfunction

  task report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task compare_field(string name, int unsigned got, int unsigned want);
    if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // accepted result transaction: compare against the oldest prediction
  task check_reading(reading_t got);
    reading_t want;
    if (expected_readings.size() == 0) begin
      report("reading with no valid frame pending");
      return;
    end
    want = expected_readings.pop_front();
    compare_field("water_full_open", got.water_full_open, want.water_full_open);
    compare_field("sleep_request", got.sleep_request, want.sleep_request);
    compare_field("pan_motor_fault", got.pan_motor_fault, want.pan_motor_fault);
    compare_field("coil_reading", got.coil_reading, want.coil_reading);
    compare_field("compressor_reading", got.compressor_reading, want.compressor_reading);
    compare_field("room_sensor_word", got.room_sensor_word, want.room_sensor_word);
    compare_field("humidity_avg", got.humidity_avg, want.humidity_avg);
    compare_field("sensor_fault", got.sensor_fault, want.sensor_fault);
  endtask
endclass

module sensor_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_BYTES    = 9;
  localparam int AVERAGE_DEPTH  = 5;
  localparam int RANDOM_BYTES   = 1600;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        in_frame_start;
  logic        out_valid;
  logic        out_stall;
  logic        out_water_full_open;
  logic        out_sleep_request;
  logic        out_pan_motor_fault;
  logic [8:0]  out_coil_reading;
  logic [9:0]  out_compressor_reading;
  logic [15:0] out_room_sensor_word;
  logic [6:0]  out_humidity_avg;
  logic        out_sensor_fault;
  reading_t    out_reading;

  frame_scoreboard sb = new(FRAME_BYTES, AVERAGE_DEPTH);
  bit          no_idle = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;

  sensor_frame_receiver #(
    .FRAME_BYTES  (FRAME_BYTES),
    .AVERAGE_DEPTH(AVERAGE_DEPTH)
  ) u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_rx_byte            (in_rx_byte),
    .in_frame_start        (in_frame_start),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_water_full_open   (out_water_full_open),
    .out_sleep_request     (out_sleep_request),
    .out_pan_motor_fault   (out_pan_motor_fault),
    .out_coil_reading      (out_coil_reading),
    .out_compressor_reading(out_compressor_reading),
    .out_room_sensor_word  (out_room_sensor_word),
    .out_humidity_avg      (out_humidity_avg),
    .out_sensor_fault      (out_sensor_fault)
  );

  assign out_reading = {out_water_full_open, out_sleep_request, out_pan_motor_fault,
                        out_coil_reading, out_compressor_reading, out_room_sensor_word,
                        out_humidity_avg, out_sensor_fault};

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // observe both channels at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.decode_link_byte(in_rx_byte, in_frame_start);
      if (out_valid && !out_stall) sb.check_reading(out_reading);
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: stall a random number of cycles once a reading shows up
  initial begin
    int unsigned hold;
    out_stall <= 1'b0;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 14);
      if (hold == 0) begin
        out_stall <= 1'b0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
        repeat (hold - 1) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end
    end
  end

  // byte values leaning toward the extremes
  function automatic bit [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // one input transaction with a random lead-in gap
  task automatic send_byte(input bit [7:0] b, input bit start);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_rx_byte     <= b;
    in_frame_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // header, seven body bytes (byte1 in the low bits), filler, crc; length cuts it short
  task automatic send_frame(input bit [7:0] hdr, input bit [55:0] body,
                            input bit [7:0] crc_flip, input int unsigned length);
    bit [7:0] frame_byte;
    bit [7:0] crc;
    crc = 8'h00;
    for (int k = 0; k < length; k++) begin
      if (k == 0) frame_byte = hdr;
      else if (k < FRAME_BYTES - 1 && k <= 7) frame_byte = body[8*(k-1) +: 8];
      else if (k < FRAME_BYTES - 1) frame_byte = pick_byte();
      else frame_byte = crc ^ crc_flip;
      send_byte(frame_byte, k == 0);
      crc = sb.crc_update(crc, frame_byte);
    end
  endtask

  // hold the sender until every predicted reading has come out
  task automatic drain_readings();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_readings.size() != 0) @(posedge clk);
  endtask

  initial begin
    bit [55:0]   body;
    bit [7:0]    hdr;
    int unsigned kind;
    int unsigned frames;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_rx_byte     <= 8'h00;
    in_frame_start <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // every field at its top value
    send_frame(HEADER_BYTE, {{5{8'hFF}}, 8'h0F, 8'h07}, 8'h00, FRAME_BYTES);
    // byte outside a frame is dropped
    send_byte(8'h5A, 1'b0);
    // partial frame abandoned by a restart
    send_frame(HEADER_BYTE, 56'h0, 8'h00, 2);
    // bad header, all-zero body
    send_frame(8'h55, 56'h0, 8'h00, FRAME_BYTES);
    // bad crc
    send_frame(HEADER_BYTE, 56'h0, 8'h01, FRAME_BYTES);
    // good frame with all-zero fields
    send_frame(HEADER_BYTE, 56'h0, 8'h00, FRAME_BYTES);
    drain_readings();

    // random mix: mostly well-formed frames, some broken ones and noise
    frames = 0;
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (frames % 20 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (frames % 60 == 59) drain_readings();
      body = {pick_byte(), pick_byte(), pick_byte(), pick_byte(),
              pick_byte(), pick_byte(), pick_byte()};
      kind = $urandom_range(0, 99);
      if (kind < 76) begin
        send_frame(HEADER_BYTE, body, 8'h00, FRAME_BYTES);
      end else if (kind < 84) begin
        send_frame(HEADER_BYTE, body, 8'($urandom_range(1, 255)), FRAME_BYTES);
      end else if (kind < 90) begin
        hdr = pick_byte();
        while (hdr == HEADER_BYTE) hdr = pick_byte();
        send_frame(hdr, body, 8'h00, FRAME_BYTES);
      end else if (kind < 96) begin
        send_frame(HEADER_BYTE, body, 8'h00, $urandom_range(1, FRAME_BYTES - 1));
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(pick_byte(), 1'b0);
      end
      frames++;
    end

    // let the last readings come out, then a short settle
    drain_readings();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_readings.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
+incdir+hdl
hdl/sfr_pkg.sv
hdl/sfr_crc8.sv
hdl/sfr_hum_avg.sv
hdl/sensor_frame_receiver.sv
hdl/sfr_checker.sv
dv/sensor_frame_receiver_tb.sv
